// File: rtl/core/assert_macros.svh
// Assertion macros shared by the run-length encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define RLED_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define RLED_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: rtl/core/rled_pkg.sv
// Shared constants, types and helper functions of the run-length encoder.
package rled_pkg;

  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned DEC_CAP    = 99999;

  // Run limit: all ones in COUNT_BITS, capped so a count has at most five digits.
  function automatic int unsigned calc_limit();
    longint unsigned full;
    full = (64'd1 << COUNT_BITS) - 64'd1;
    if (full > 64'(DEC_CAP)) full = 64'(DEC_CAP);
    if (full < 64'd1) full = 64'd1;
    return int'(full);
  endfunction

  function automatic int unsigned count_digits(int unsigned value);
    int unsigned v;
    int unsigned n;
    v = value;
    n = 0;
    for (int i = 0; i < 10; i++) begin
      if (v != 0) begin
        n = n + 1;
        v = v / 10;
      end
    end
    return n;
  endfunction

  localparam int unsigned RUN_LIMIT    = calc_limit();
  localparam int unsigned LEN_BITS     = $clog2(RUN_LIMIT + 1);
  localparam int unsigned NUM_DIGITS   = count_digits(RUN_LIMIT);
  localparam int unsigned DIG_CNT_BITS = $clog2(NUM_DIGITS + 1);
  localparam int unsigned DIG_IDX_BITS = $clog2(NUM_DIGITS);

  // x / 10 == (x * RECIP) >> RECIP_SHIFT, exact for x below 2^22.
  localparam int unsigned RECIP_BITS  = 20;
  localparam int unsigned RECIP_SHIFT = 23;
  localparam logic [RECIP_BITS-1:0] RECIP = 20'hCCCCD;

  localparam logic [7:0] ASCII_ZERO = 8'h30;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SYM,
    ST_DIG
  } state_t;

  typedef struct packed {
    logic accept;
    logic load_sym;
    logic load_dig;
    logic load_pend;
  } dp_cmd_t;

  typedef struct packed {
    logic has_job;
    logic slot_free;
    logic conv_done;
    logic last_digit;
    logic pend;
  } dp_status_t;

endpackage

// File: rtl/core/rled_ctrl.sv
// Controller state machine: sequences symbol and digit beats of each run.
`include "assert_macros.svh"

module rled_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rled_pkg::dp_status_t status,
  output rled_pkg::dp_cmd_t   cmd
);
  import rled_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && status.has_job) state_next = ST_SYM;
      end
      ST_SYM: begin
        if (status.slot_free) begin
          cmd.load_sym = 1'b1;
          state_next   = ST_DIG;
        end
      end
      ST_DIG: begin
        if (status.conv_done && status.slot_free) begin
          cmd.load_dig = 1'b1;
          if (status.last_digit) begin
            // start the one-byte run that followed a byte change, or go idle
            if (status.pend) begin
              cmd.load_pend = 1'b1;
              state_next    = ST_SYM;
            end else begin
              state_next = ST_IDLE;
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `RLED_ASSERT(a_job_starts_sym, (cmd.accept && status.has_job) |=> (state == ST_SYM),
    "accepted beat that closes a run did not start emission")
  `RLED_NEVER(a_pop_before_conv, cmd.load_dig && !status.conv_done,
    "digit popped before conversion finished")

endmodule

// File: rtl/core/rled_dp.sv
// Datapath: run tracking, divide-by-ten digit conversion and output register.
`include "assert_macros.svh"

module rled_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output logic [7:0]          out_byte,
  output logic                out_last,
  output logic                out_valid,
  input  logic                out_ready,
  input  rled_pkg::dp_cmd_t   cmd,
  output rled_pkg::dp_status_t status
);
  import rled_pkg::*;

  // open run
  logic [7:0]          run_symbol;
  logic [LEN_BITS-1:0] run_length;
  logic                run_open;

  // run being emitted
  logic [7:0]              job_sym;
  logic [LEN_BITS-1:0]     job_val;
  logic                    job_last;
  logic [3:0]              dig [NUM_DIGITS];
  logic [DIG_CNT_BITS-1:0] dig_cnt;

  // one-byte run queued behind the emitted one
  logic pend;
  logic pend_last;

  logic                          same;
  logic [LEN_BITS-1:0]           len_inc;
  logic                          hit;
  logic                          has_job;
  logic                          slot_free;
  logic [LEN_BITS+RECIP_SHIFT-1:0] prod;
  logic [LEN_BITS-1:0]           quot;
  logic [LEN_BITS-1:0]           rem_full;
  logic [DIG_CNT_BITS-1:0]       pop_cnt;

  // while a run is open its length stays below the limit, so +1 fits
  assign same      = run_open && (in_byte == run_symbol);
  assign len_inc   = run_length + LEN_BITS'(1);
  assign hit       = (32'(len_inc) >= RUN_LIMIT);
  assign has_job   = same ? (hit || in_last) : (run_open || in_last);
  assign slot_free = !out_valid || out_ready;

  assign prod     = (LEN_BITS + RECIP_SHIFT)'(job_val) * (LEN_BITS + RECIP_SHIFT)'(RECIP);
  assign quot     = LEN_BITS'(prod >> RECIP_SHIFT);
  assign rem_full = job_val - ((quot << 3) + (quot << 1));
  assign pop_cnt  = dig_cnt - DIG_CNT_BITS'(1);

  assign status.has_job    = has_job;
  assign status.slot_free  = slot_free;
  assign status.conv_done  = (job_val == '0);
  assign status.last_digit = (dig_cnt == DIG_CNT_BITS'(1));
  assign status.pend       = pend;

  // run state
  always_ff @(posedge clk) begin
    if (rst) begin
      run_symbol <= '0;
      run_length <= '0;
      run_open   <= 1'b0;
    end else if (cmd.accept) begin
      if (same) begin
        if (hit || in_last) begin
          run_open   <= 1'b0;
          run_length <= '0;
        end else begin
          run_length <= len_inc;
        end
      end else begin
        // a fresh run never reaches the limit at length one
        run_symbol <= in_byte;
        run_open   <= !in_last;
        run_length <= in_last ? '0 : LEN_BITS'(1);
      end
    end
  end

  // emission job and digit conversion
  always_ff @(posedge clk) begin
    if (rst) begin
      job_val   <= '0;
      dig_cnt   <= '0;
      pend      <= 1'b0;
      pend_last <= 1'b0;
    end else if (cmd.accept && has_job) begin
      dig_cnt <= '0;
      if (same) begin
        job_sym  <= run_symbol;
        job_val  <= len_inc;
        job_last <= in_last;
      end else if (run_open) begin
        job_sym   <= run_symbol;
        job_val   <= run_length;
        job_last  <= 1'b0;
        pend      <= in_last;
        pend_last <= in_last;
      end else begin
        job_sym  <= in_byte;
        job_val  <= LEN_BITS'(1);
        job_last <= in_last;
      end
    end else if (cmd.load_pend) begin
      job_sym  <= run_symbol;
      job_val  <= LEN_BITS'(1);
      job_last <= pend_last;
      dig_cnt  <= '0;
      pend     <= 1'b0;
    end else if (job_val != '0) begin
      // one digit per cycle, least significant first
      dig[dig_cnt[DIG_IDX_BITS-1:0]] <= rem_full[3:0];
      job_val <= quot;
      dig_cnt <= dig_cnt + DIG_CNT_BITS'(1);
    end else if (cmd.load_dig) begin
      dig_cnt <= pop_cnt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_sym || cmd.load_dig) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sym) begin
      out_byte <= job_sym;
      out_last <= 1'b0;
    end else if (cmd.load_dig) begin
      out_byte <= ASCII_ZERO + {4'b0, dig[pop_cnt[DIG_IDX_BITS-1:0]]};
      out_last <= job_last && status.last_digit;
    end
  end

  `RLED_ASSERT(a_pend_closed, pend |-> !run_open,
    "queued one-byte run while a run is still open")
  `RLED_NEVER(a_dig_overflow, 32'(dig_cnt) > NUM_DIGITS,
    "digit count beyond the widest run length")
  `RLED_ASSERT(a_load_slot, (cmd.load_sym || cmd.load_dig) |-> slot_free,
    "output register overwritten while holding a beat")

endmodule

// File: rtl/core/run_length_encoder_decimal_top.sv
// Run-length encoder with decimal counts: top level.
// Input channel: one byte per beat (in_byte, in_last) on in_valid/in_ready.
// Output channel: one byte per beat (out_byte, out_last) on out_valid/out_ready.
// Equal consecutive bytes form a run. When a run closes (byte change, last
// mark, or the run reaching 65535 bytes) the block sends the run byte and then
// the length in ASCII decimal, most significant digit first; out_last marks
// the final digit of a string. A byte that only extends a run leaves the
// block idle and ready. A beat that closes a run holds the input while the
// run byte is sent, the divide-by-ten unit makes one digit per cycle and the
// digits are sent one per beat. A byte change with a last mark sends two runs,
// the second a one-byte run. The closing beat moves the controller to ST_SYM,
// which loads the run byte into the output register once it is free. Reset
// clears the open run and the output valid flag; no run is pending afterwards.
// On a receiver stall the output register holds its beat and the block waits;
// input is accepted again once all of a run's digits are in the output register.
module run_length_encoder_decimal_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);
  import rled_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  rled_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rled_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// File: dv/run_length_encoder_decimal_top_test.sv
// Self-checking testbench for the run-length encoder with decimal counts.
module run_length_encoder_decimal_top_test;

  localparam longint unsigned FULL_COUNT = (64'd1 << rled_pkg::COUNT_BITS) - 64'd1;
  localparam int unsigned RUN_CAP = (FULL_COUNT > 64'd99999) ? 99999 : int'(FULL_COUNT);
  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam int unsigned DEC_BASE = 10;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_BEATS = 200;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } encoded_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;

  // Open run as the encoder should hold it.
  logic [7:0]  run_sym = 8'h00;
  int unsigned run_len = 0;
  bit          run_open = 1'b0;

  encoded_beat_t encoded_q[$];

  int unsigned tx_gap_max = 6;
  int unsigned rx_gap_max = 6;
  int unsigned rx_wait = 0;
  bit          out_taken = 1'b0;
  int unsigned stall_cycles = 0;

  int unsigned mismatches = 0;
  int unsigned beats_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned strings_sent = 0;
  int unsigned closed_by_change = 0;
  int unsigned closed_by_last = 0;
  int unsigned closed_by_limit = 0;
  int unsigned longest_run = 0;

  run_length_encoder_decimal_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Queue the run byte, then the length in decimal, most significant digit first.
  function automatic void push_run(logic [7:0] sym, int unsigned len, logic fin);
    logic [7:0]  digs[$];
    int unsigned v;
    v = len;
    if (len > longest_run) longest_run = len;
    encoded_q.push_back('{data: sym, last: 1'b0});
    do begin
      digs.push_front(DIGIT_ZERO + 8'(v % DEC_BASE));
      v = v / DEC_BASE;
    end while (v != 0);
    for (int k = 0; k < digs.size(); k++)
      encoded_q.push_back('{data: digs[k], last: fin && (k == digs.size() - 1)});
  endfunction

  function automatic void close_open_run(logic fin);
    push_run(run_sym, run_len, fin);
    if (fin) closed_by_last++;
    else closed_by_limit++;
    run_open = 1'b0;
    run_len = 0;
  endfunction

  function automatic void predict_encoded(logic [7:0] b, logic fin);
    if (run_open && b == run_sym) begin
      run_len++;
      if (run_len >= RUN_CAP || fin) close_open_run(fin);
    end else begin
      if (run_open) begin
        push_run(run_sym, run_len, 1'b0);
        closed_by_change++;
      end
      run_sym = b;
      run_len = 1;
      run_open = 1'b1;
      if (run_len >= RUN_CAP || fin) close_open_run(fin);
    end
    if (fin) strings_sent++;
  endfunction

  // Entered and left at a falling edge.
  task automatic send_beat(input logic [7:0] b, input logic fin, input int unsigned gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= fin;
    do @(posedge clk); while (!in_ready);
    predict_encoded(b, fin);
    beats_sent++;
    @(negedge clk);
  endtask

  // Only the edges of a long run idle, so long runs stay fast.
  task automatic send_run(input logic [7:0] sym, input int unsigned len, input logic fin);
    int unsigned gap;
    for (int unsigned i = 0; i < len; i++) begin
      gap = (i < 4 || i + 4 >= len) ? $urandom_range(0, tx_gap_max) : 0;
      send_beat(sym, fin && (i == len - 1), gap);
    end
  endtask

  task automatic test_short_strings();
    send_run(8'h00, 2, 1'b1);
    send_run(8'hFF, 1, 1'b1);
    send_run("a", 2, 1'b0);
    send_run("b", 3, 1'b0);
    send_run("c", 1, 1'b1);
    // byte change and last mark on the same beat
    send_run("x", 2, 1'b0);
    send_run("y", 1, 1'b1);
    // same byte right after a last mark opens a new string
    send_run("z", 2, 1'b1);
    send_run("z", 1, 1'b1);
    send_run(8'h55, 1, 1'b0);
    send_run(8'hAA, 1, 1'b0);
    send_run(8'h55, 1, 1'b1);
    send_run(8'h80, 1, 1'b0);
    send_run(8'h7F, 1, 1'b1);
  endtask

  task automatic test_digit_widths();
    int unsigned widths[4] = '{9, 10, 99, 100};
    for (int i = 0; i < 4; i++)
      send_run(8'h41 + 8'(i), widths[i], i % 2 == 1);
    // two-digit run closed by a one-byte last run
    send_run("q", 12, 1'b0);
    send_run("r", 1, 1'b1);
  endtask

  task automatic test_random_strings();
    int unsigned start_count;
    int unsigned n_runs;
    int unsigned len;
    int unsigned pick;
    logic [7:0]  sym;
    start_count = beats_sent;
    while (beats_sent - start_count < RANDOM_BEATS) begin
      tx_gap_max = ($urandom_range(0, 4) == 0) ? 0 : 6;
      rx_gap_max = ($urandom_range(0, 4) == 0) ? 0 : 6;
      if ($urandom_range(0, 9) < 2) begin
        // noise: arbitrary bytes, last mark anywhere
        repeat ($urandom_range(1, 6))
          send_beat(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, tx_gap_max));
      end else begin
        n_runs = $urandom_range(1, 6);
        for (int unsigned r = 0; r < n_runs; r++) begin
          sym = ($urandom_range(0, 1) == 0) ? 8'("a" + $urandom_range(0, 2)) : 8'($urandom);
          pick = $urandom_range(0, 15);
          if (pick < 10) len = $urandom_range(1, 3);
          else if (pick < 14) len = $urandom_range(4, 20);
          else len = $urandom_range(21, 120);
          send_run(sym, len, r == n_runs - 1);
        end
      end
    end
    send_beat(8'($urandom), 1'b1, 0);
    tx_gap_max = 6;
    rx_gap_max = 6;
  endtask

  // Check every output beat against the oldest queued one.
  always @(posedge clk) begin
    encoded_beat_t want;
    if (!rst && out_valid && out_ready) begin
      out_taken = 1'b1;
      beats_checked++;
      if (encoded_q.size() == 0) begin
        $display("%0t: unexpected output beat out_byte %02h out_last %0b",
                 $time, out_byte, out_last);
        mismatches++;
      end else begin
        want = encoded_q.pop_front();
        if (out_byte !== want.data) begin
          $display("%0t: out_byte expected %02h got %02h", $time, want.data, out_byte);
          mismatches++;
        end
        if (out_last !== want.last) begin
          $display("%0t: out_last expected %0b got %0b", $time, want.last, out_last);
          mismatches++;
        end
      end
    end
  end

  // Receiver: after each beat, drop ready for a drawn number of cycles.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else if (out_ready) begin
      if (out_taken) begin
        rx_wait = $urandom_range(0, rx_gap_max);
        if (rx_wait != 0) out_ready <= 1'b0;
      end
    end else if (rx_wait > 1) begin
      rx_wait--;
    end else begin
      out_ready <= 1'b1;
    end
    out_taken = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles, %0d output beats outstanding",
                 $time, stall_cycles, encoded_q.size());
        $display("run_length_encoder_decimal_top_test NOT OK");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_short_strings();
    test_digit_widths();
    test_random_strings();
    in_valid <= 1'b0;
    wait (encoded_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d input beats in %0d strings; checked %0d output beats, longest run %0d.",
             beats_sent, strings_sent, beats_checked, longest_run);
    $display("Runs closed by byte change %0d, by last mark %0d, by run limit %0d.",
             closed_by_change, closed_by_last, closed_by_limit);
    if (mismatches == 0 && encoded_q.size() == 0) begin
      $display("run_length_encoder_decimal_top_test OK");
    end else begin
      $display("run_length_encoder_decimal_top_test NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/rled_pkg.sv
rtl/core/rled_ctrl.sv
rtl/core/rled_dp.sv
rtl/core/run_length_encoder_decimal_top.sv
dv/run_length_encoder_decimal_top_test.sv
